// ----- rtl/ws2i_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ws2i_pkg;

  localparam logic [2:0] FMT_PCM8  = 3'd0;
  localparam logic [2:0] FMT_PCM16 = 3'd1;
  localparam logic [2:0] FMT_PCM24 = 3'd2;
  localparam logic [2:0] FMT_PCM32 = 3'd3;
  localparam logic [2:0] FMT_F32   = 3'd4;
  localparam logic [2:0] FMT_F64   = 3'd5;

  localparam logic [2:0]  FMT_RESET  = FMT_PCM16;
  localparam logic [14:0] FULL_SCALE = 15'd32767;

  typedef struct packed {
    logic [2:0]  fmt;
    logic [15:0] pcm;
    logic        neg;
    logic        fzero;
    logic        ffull;
  } side_t;

endpackage

`default_nettype wire

// ----- rtl/wav_sample_to_int16_converter.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Converts one raw WAV sample word per clock into a signed 16-bit sample. A sample is
// taken whenever start is high; busy is always low, so the block accepts a new word in
// every cycle. Each result appears on sample_out after the five-stage float path (exact
// mantissa product, first rounding, half-offset add, second rounding, final shift and
// clamp), marked by a one-cycle done pulse, in the order the words were taken; PCM words
// travel through the same stages. The format register is written through
// cfg_valid/cfg_ready/cfg_data, is always ready, and applies to words accepted after the
// transfer.
module wav_sample_to_int16_converter
  import ws2i_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [63:0]        sample_bits,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_data,
  output logic signed [15:0]      sample_out,
  output logic                    done
);

  logic [2:0] sample_format;

  logic v1, v2, v3, v4;
  side_t side1, side2, side3, side4;
  logic [67:0] p1;
  logic [4:0]  ueneg1;
  logic [53:0] q2;
  logic [5:0]  sh2, sh3, sh4;
  logic [54:0] s3, s4;

  // Stage 1: decode, PCM conversion and exact mantissa product.
  logic        is_f64;
  logic [10:0] exp_raw;
  logic [51:0] frac52;
  logic        exp_max;
  logic        nan;
  logic signed [12:0] ue;
  logic [12:0] ue_neg;
  logic [52:0] mant;
  logic [67:0] prod;
  logic [31:0] pcm_raw;
  logic [31:0] pcm_mag;
  logic [32:0] pcm_sum;
  logic [16:0] pcm_r;
  logic [15:0] pcm_scaled;
  side_t       side_in;

  always_comb begin
    is_f64  = (sample_format == FMT_F64);
    exp_raw = is_f64 ? sample_bits[62:52] : {3'b000, sample_bits[30:23]};
    frac52  = is_f64 ? sample_bits[51:0] : {sample_bits[22:0], 29'd0};
    exp_max = is_f64 ? (exp_raw == 11'h7FF) : (exp_raw[7:0] == 8'hFF);
    nan     = exp_max && (frac52 != 52'd0);
    ue      = $signed({2'b00, exp_raw}) - (is_f64 ? 13'sd1023 : 13'sd127);
    ue_neg  = 13'd0 - ue;
    mant    = {1'b1, frac52};
    prod    = {mant, 15'd0} - {15'd0, mant};

    if (sample_format == FMT_PCM24) begin
      pcm_raw = {{8{sample_bits[23]}}, sample_bits[23:0]};
    end else begin
      pcm_raw = sample_bits[31:0];
    end
    pcm_mag = pcm_raw[31] ? (32'd0 - pcm_raw) : pcm_raw;
    if (sample_format == FMT_PCM24) begin
      pcm_sum = {1'b0, pcm_mag} + 33'd128;
      pcm_r   = pcm_sum[24:8];
    end else begin
      pcm_sum = {1'b0, pcm_mag} + 33'd32768;
      pcm_r   = pcm_sum[32:16];
    end
    if (pcm_raw[31]) begin
      pcm_scaled = 16'd0 - pcm_r[15:0];
    end else if (pcm_r > 17'd32767) begin
      pcm_scaled = {1'b0, FULL_SCALE};
    end else begin
      pcm_scaled = pcm_r[15:0];
    end

    side_in.fmt = sample_format;
    unique case (sample_format)
      FMT_PCM8:  side_in.pcm = {~sample_bits[7], sample_bits[6:0], 8'd0};
      FMT_PCM16: side_in.pcm = sample_bits[15:0];
      default:   side_in.pcm = pcm_scaled;
    endcase
    side_in.neg   = is_f64 ? sample_bits[63] : sample_bits[31];
    side_in.ffull = !nan && !ue[12];
    side_in.fzero = nan || (ue < -13'sd16);
  end

  // Stage 2: round the product to 53 significant bits.
  logic        top;
  logic [52:0] q_trunc;
  logic [14:0] rem;
  logic [14:0] half;
  logic        round_up;

  always_comb begin
    top      = p1[67];
    q_trunc  = top ? p1[67:15] : p1[66:14];
    rem      = top ? p1[14:0] : {1'b0, p1[13:0]};
    half     = top ? 15'h4000 : 15'h2000;
    round_up = (rem > half) || ((rem == half) && q_trunc[0]);
  end

  // Stage 4: round the offset sum back to 53 significant bits.
  logic [54:0] s_adj;

  always_comb begin
    if ((s3[54:53] != 2'b00) && s3[0]) begin
      s_adj = s3[1] ? (s3 + 55'd1) : (s3 - 55'd1);
    end else begin
      s_adj = s3;
    end
  end

  // Stage 5: shift, clamp, sign and format select.
  logic [54:0]        shifted;
  logic [14:0]        fmag;
  logic [15:0]        fval;
  logic signed [15:0] result;

  always_comb begin
    shifted = s4 >> sh4;
    if (side4.ffull || (shifted[54:15] != 40'd0)) begin
      fmag = FULL_SCALE;
    end else if (side4.fzero) begin
      fmag = 15'd0;
    end else begin
      fmag = shifted[14:0];
    end
    if (side4.fzero) begin
      fmag = 15'd0;
    end
    fval = side4.neg ? (16'd0 - {1'b0, fmag}) : {1'b0, fmag};
    unique case (side4.fmt)
      FMT_PCM8, FMT_PCM16, FMT_PCM24, FMT_PCM32: result = side4.pcm;
      FMT_F32, FMT_F64:                          result = fval;
      default:                                   result = 16'sd0;
    endcase
  end

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format <= FMT_RESET;
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      done <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        sample_format <= cfg_data;
      end
      v1   <= start && !busy;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      done <= v4;
    end
  end

  always_ff @(posedge clk) begin
    side1  <= side_in;
    p1     <= prod;
    ueneg1 <= ue_neg[4:0];

    side2 <= side1;
    q2    <= {1'b0, q_trunc} + {53'd0, round_up};
    sh2   <= top ? (6'd37 + {1'b0, ueneg1}) : (6'd38 + {1'b0, ueneg1});

    side3 <= side2;
    s3    <= {1'b0, q2} + (55'd1 << (sh2 - 6'd1));
    sh3   <= sh2;

    side4 <= side3;
    s4    <= s_adj;
    sh4   <= sh3;

    sample_out <= result;
  end

endmodule

`default_nettype wire
